@@ rtl/qvr_pkg.sv @@
// Shared constants for the quaternion vector rotation unit.
// No dependencies; imported by quaternion_vector_rotate_unit.
package qvr_pkg;

  // Quaternion components are fixed at 16 bits, signed
  localparam int Q_WIDTH = 16;
  // Tolerance register width (unsigned)
  localparam int TOL_WIDTH = 29;
  // Tolerance after reset, in units of 2^-(2*frac bits)
  localparam int unsigned TOL_RESET = 268435;

  // Defaults for the top-level parameters
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF = 24;

  // Width of a rotation-matrix term: 2*(q*q - q*q) needs 34 signed bits
  localparam int MAT_WIDTH = 2 * Q_WIDTH + 2;

  // Pipeline depth from input register to output register
  localparam int NUM_STAGES = 5;

  // Output tuser bit positions
  localparam int TUSER_NOT_UNIT = 0;
  localparam int TUSER_SATURATED = 1;
  localparam int TUSER_WIDTH = 2;

endpackage

@@ rtl/quaternion_vector_rotate_unit.sv @@
// Quaternion vector rotation: a five-stage pipeline that rotates a 3-vector
// by a Q2.14 quaternion, with norm check and output saturation.
// Depends on qvr_pkg.

// One beat enters per clock unless all stages are full and out_tready is
// low. The stages are: quaternion products, matrix terms with norm check,
// nine matrix-by-vector multipliers, row sums, then rounding and clipping.
// Every stage has its own valid bit and a stage loads whenever it is empty
// or the stage after it is moving, so bubbles close up and the input keeps
// accepting while a finished result waits on out_tready, until all five
// stages are full. A quaternion whose squared norm lies more than cfg_wdata
// away from one gives a zero vector with not_unit set; a clipped component
// sets saturated. Write cfg only while the pipeline is empty.
module quaternion_vector_rotate_unit #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
  localparam int IN_DW = ((4 * qvr_pkg::Q_WIDTH + 3 * VEC_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * VEC_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: norm tolerance
  input  logic                            cfg_we,
  input  logic [qvr_pkg::TOL_WIDTH-1:0]   cfg_wdata,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata, low bit up: q_w, q_x, q_y, q_z, v_x, v_y, v_z, zero pad
  input  logic [IN_DW-1:0]                in_tdata,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata, low bit up: r_x, r_y, r_z, zero pad
  output logic [OUT_DW-1:0]               out_tdata,
  // tuser, low bit up: not_unit, saturated
  output logic [qvr_pkg::TUSER_WIDTH-1:0] out_tuser
);
  import qvr_pkg::*;

  localparam int QW = Q_WIDTH;
  localparam int VW = VEC_WIDTH;
  localparam int PQW = 2 * QW;               // quaternion product
  localparam int MW = MAT_WIDTH;             // matrix term
  localparam int SH = 2 * QUAT_FRAC_BITS;    // scale-down shift
  localparam int NW = (SH + 3 > MW + 1) ? SH + 3 : MW + 1;  // norm compare
  localparam int PW = MW + VW;               // matrix-by-vector product
  localparam int SW = PW + 2;                // row sum
  localparam int RW = (SW > SH + 1) ? SW + 1 : SH + 2;      // rounding
  localparam int PADW = OUT_DW - 3 * VW;

  localparam logic signed [NW-1:0] ONE_N = NW'(1) <<< SH;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] VMAX = (RW'(1) <<< (VW - 1)) - RW'(1);
  localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

  // ---------------------------------------------------------------------
  // Tolerance window, kept as lower and upper bounds on the squared norm
  logic signed [NW-1:0] tol_lo_r, tol_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_lo_r <= ONE_N - NW'(TOL_RESET);
      tol_hi_r <= ONE_N + NW'(TOL_RESET);
    end else if (cfg_we) begin
      tol_lo_r <= ONE_N - $signed({{(NW-TOL_WIDTH){1'b0}}, cfg_wdata});
      tol_hi_r <= ONE_N + $signed({{(NW-TOL_WIDTH){1'b0}}, cfg_wdata});
    end
  end

  // ---------------------------------------------------------------------
  // Stage valid bits and ready chain; index 0 is the first stage
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];

  // ---------------------------------------------------------------------
  // Stage 1: the ten quaternion products
  logic signed [QW-1:0] q_w, q_x, q_y, q_z;
  logic signed [VW-1:0] v_x, v_y, v_z;

  assign q_w = in_tdata[QW-1:0];
  assign q_x = in_tdata[2*QW-1:QW];
  assign q_y = in_tdata[3*QW-1:2*QW];
  assign q_z = in_tdata[4*QW-1:3*QW];
  assign v_x = in_tdata[4*QW+VW-1:4*QW];
  assign v_y = in_tdata[4*QW+2*VW-1:4*QW+VW];
  assign v_z = in_tdata[4*QW+3*VW-1:4*QW+2*VW];

  logic signed [PQW-1:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [PQW-1:0] p_xy_r, p_xz_r, p_yz_r, p_wx_r, p_wy_r, p_wz_r;
  logic signed [VW-1:0] s1_vx_r, s1_vy_r, s1_vz_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_ww_r <= PQW'(q_w) * PQW'(q_w);
      p_xx_r <= PQW'(q_x) * PQW'(q_x);
      p_yy_r <= PQW'(q_y) * PQW'(q_y);
      p_zz_r <= PQW'(q_z) * PQW'(q_z);
      p_xy_r <= PQW'(q_x) * PQW'(q_y);
      p_xz_r <= PQW'(q_x) * PQW'(q_z);
      p_yz_r <= PQW'(q_y) * PQW'(q_z);
      p_wx_r <= PQW'(q_w) * PQW'(q_x);
      p_wy_r <= PQW'(q_w) * PQW'(q_y);
      p_wz_r <= PQW'(q_w) * PQW'(q_z);
      s1_vx_r <= v_x;
      s1_vy_r <= v_y;
      s1_vz_r <= v_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: rotation-matrix terms and squared-norm window check
  logic signed [MW-1:0] ww_m, xx_m, yy_m, zz_m, xy_m, xz_m, yz_m, wx_m, wy_m, wz_m;
  logic signed [NW-1:0] norm2;
  logic                 not_unit_nxt;

  assign ww_m = MW'(p_ww_r);
  assign xx_m = MW'(p_xx_r);
  assign yy_m = MW'(p_yy_r);
  assign zz_m = MW'(p_zz_r);
  assign xy_m = MW'(p_xy_r);
  assign xz_m = MW'(p_xz_r);
  assign yz_m = MW'(p_yz_r);
  assign wx_m = MW'(p_wx_r);
  assign wy_m = MW'(p_wy_r);
  assign wz_m = MW'(p_wz_r);

  assign norm2 = NW'(p_ww_r) + NW'(p_xx_r) + NW'(p_yy_r) + NW'(p_zz_r);
  assign not_unit_nxt = (norm2 > tol_hi_r) || (norm2 < tol_lo_r);

  logic signed [MW-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;
  logic signed [VW-1:0] s2_vx_r, s2_vy_r, s2_vz_r;
  logic                 s2_nu_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m00_r <= ww_m + xx_m - yy_m - zz_m;
      m01_r <= (xy_m - wz_m) <<< 1;
      m02_r <= (xz_m + wy_m) <<< 1;
      m10_r <= (xy_m + wz_m) <<< 1;
      m11_r <= ww_m - xx_m + yy_m - zz_m;
      m12_r <= (yz_m - wx_m) <<< 1;
      m20_r <= (xz_m - wy_m) <<< 1;
      m21_r <= (yz_m + wx_m) <<< 1;
      m22_r <= ww_m - xx_m - yy_m + zz_m;
      s2_vx_r <= s1_vx_r;
      s2_vy_r <= s1_vy_r;
      s2_vz_r <= s1_vz_r;
      s2_nu_r <= not_unit_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: nine matrix-by-vector products
  logic signed [PW-1:0] pv00_r, pv01_r, pv02_r, pv10_r, pv11_r, pv12_r;
  logic signed [PW-1:0] pv20_r, pv21_r, pv22_r;
  logic                 s3_nu_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pv00_r <= PW'(m00_r) * PW'(s2_vx_r);
      pv01_r <= PW'(m01_r) * PW'(s2_vy_r);
      pv02_r <= PW'(m02_r) * PW'(s2_vz_r);
      pv10_r <= PW'(m10_r) * PW'(s2_vx_r);
      pv11_r <= PW'(m11_r) * PW'(s2_vy_r);
      pv12_r <= PW'(m12_r) * PW'(s2_vz_r);
      pv20_r <= PW'(m20_r) * PW'(s2_vx_r);
      pv21_r <= PW'(m21_r) * PW'(s2_vy_r);
      pv22_r <= PW'(m22_r) * PW'(s2_vz_r);
      s3_nu_r <= s2_nu_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: exact row sums
  logic signed [SW-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic                 s4_nu_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sum_x_r <= SW'(pv00_r) + SW'(pv01_r) + SW'(pv02_r);
      sum_y_r <= SW'(pv10_r) + SW'(pv11_r) + SW'(pv12_r);
      sum_z_r <= SW'(pv20_r) + SW'(pv21_r) + SW'(pv22_r);
      s4_nu_r <= s3_nu_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: round half away from zero, clip, zero on rejected quaternion
  // For a negative sum, subtracting one before the floor shift turns
  // round-half-up into round-half-away.
  logic signed [RW-1:0] rnd_x, rnd_y, rnd_z;
  logic signed [RW-1:0] adj_x, adj_y, adj_z;
  logic                 clip_x, clip_y, clip_z;
  logic [VW-1:0]        res_x, res_y, res_z;

  assign adj_x = RW'(sum_x_r) + HALF - $signed({{(RW-1){1'b0}}, sum_x_r[SW-1]});
  assign adj_y = RW'(sum_y_r) + HALF - $signed({{(RW-1){1'b0}}, sum_y_r[SW-1]});
  assign adj_z = RW'(sum_z_r) + HALF - $signed({{(RW-1){1'b0}}, sum_z_r[SW-1]});
  assign rnd_x = adj_x >>> SH;
  assign rnd_y = adj_y >>> SH;
  assign rnd_z = adj_z >>> SH;

  always_comb begin
    clip_x = (rnd_x > VMAX) || (rnd_x < VMIN);
    clip_y = (rnd_y > VMAX) || (rnd_y < VMIN);
    clip_z = (rnd_z > VMAX) || (rnd_z < VMIN);
    res_x = (rnd_x > VMAX) ? VMAX[VW-1:0] : (rnd_x < VMIN) ? VMIN[VW-1:0] : rnd_x[VW-1:0];
    res_y = (rnd_y > VMAX) ? VMAX[VW-1:0] : (rnd_y < VMIN) ? VMIN[VW-1:0] : rnd_y[VW-1:0];
    res_z = (rnd_z > VMAX) ? VMAX[VW-1:0] : (rnd_z < VMIN) ? VMIN[VW-1:0] : rnd_z[VW-1:0];
  end

  logic [VW-1:0] r_x_r, r_y_r, r_z_r;
  logic          not_unit_r, saturated_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      r_x_r       <= s4_nu_r ? '0 : res_x;
      r_y_r       <= s4_nu_r ? '0 : res_y;
      r_z_r       <= s4_nu_r ? '0 : res_z;
      not_unit_r  <= s4_nu_r;
      saturated_r <= !s4_nu_r && (clip_x || clip_y || clip_z);
    end
  end

  generate
    if (PADW > 0) begin : g_pad
      assign out_tdata = {{PADW{1'b0}}, r_z_r, r_y_r, r_x_r};
    end else begin : g_nopad
      assign out_tdata = {r_z_r, r_y_r, r_x_r};
    end
  endgenerate

  always_comb begin
    out_tuser = '0;
    out_tuser[TUSER_NOT_UNIT] = not_unit_r;
    out_tuser[TUSER_SATURATED] = saturated_r;
  end

  // ---------------------------------------------------------------------
  // Checks
`ifndef SYNTH
  // Input stalls only when every stage holds a beat and the sink is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&vld_r) && !out_tready))
    else $error("input stalled with a free pipeline stage");

  // A rejected quaternion gives a zero vector and no saturation flag
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && not_unit_r) |-> (r_x_r == '0 && r_y_r == '0 && r_z_r == '0
                                    && !saturated_r))
    else $error("rejected beat carries data or saturation");

  // A saturated beat has at least one component at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && saturated_r) |->
      (r_x_r == VMAX[VW-1:0] || r_x_r == VMIN[VW-1:0] ||
       r_y_r == VMAX[VW-1:0] || r_y_r == VMIN[VW-1:0] ||
       r_z_r == VMAX[VW-1:0] || r_z_r == VMIN[VW-1:0]))
    else $error("saturated flag without a clipped component");

  // Tolerance window never inverts
  a_tol_order: assert property (@(posedge clk) disable iff (!rst_n)
    tol_lo_r <= tol_hi_r)
    else $error("tolerance bounds out of order");
`endif

endmodule

@@ tb/sv/quaternion_vector_rotate_unit_tb.sv @@
// Self-checking testbench for quaternion_vector_rotate_unit: directed and random
// rotations checked against a behavioral predictor, under stream backpressure.
// Depends on qvr_pkg and the quaternion_vector_rotate_unit RTL.
module quaternion_vector_rotate_unit_tb;
  import qvr_pkg::*;

  localparam int FRAC = QUAT_FRAC_BITS_DEF;
  localparam int VEC_W = VEC_WIDTH_DEF;
  localparam int IN_DW = ((4 * Q_WIDTH + 3 * VEC_W + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * VEC_W + 7) / 8) * 8;

  // Constants: UNIT_SQ, HALF_LSB and TOL_ONE at the product scale Q(2*FRAC), Q_ONE at Q(FRAC)
  localparam longint UNIT_SQ = longint'(1) << (2 * FRAC);
  localparam longint HALF_LSB = longint'(1) << (2 * FRAC - 1);
  localparam longint VEC_MAX = (longint'(1) << (VEC_W - 1)) - 1;
  localparam longint VEC_MIN = -VEC_MAX - 1;
  localparam int unsigned TOL_ONE = 1 << (2 * FRAC);
  localparam int Q_ONE = 1 << FRAC;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 140;

  // Packed so the member order matches the tdata layout (q_w in the low bits)
  typedef struct packed {
    logic signed [VEC_W-1:0] v_z, v_y, v_x;
    logic signed [Q_WIDTH-1:0] q_z, q_y, q_x, q_w;
  } rot_item_t;

  typedef struct packed {
    logic saturated;
    logic not_unit;
    logic signed [VEC_W-1:0] r_z, r_y, r_x;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [TOL_WIDTH-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // tdata, low bit up: q_w, q_x, q_y, q_z, v_x, v_y, v_z
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // tdata, low bit up: r_x, r_y, r_z
  logic [OUT_DW-1:0] out_tdata;
  // tuser, low bit up: not_unit, saturated
  logic [TUSER_WIDTH-1:0] out_tuser;

  // Predictor copy of the tolerance register and the expected result store
  logic [TOL_WIDTH-1:0] tolerance_now = TOL_WIDTH'(TOL_RESET);
  rot_result_t pending_rotations[$];
  int mismatch_count = 0;
  int in_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  quaternion_vector_rotate_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Round half away from zero, then clip to the vector range
  function automatic logic signed [VEC_W-1:0] round_clip(input longint acc,
                                                         output bit hit);
    longint mag, q;
    hit = 1'b0;
    mag = (acc < 0) ? -acc : acc;
    q = (mag + HALF_LSB) >>> (2 * FRAC);
    if (acc < 0) q = -q;
    if (q > VEC_MAX) begin
      q = VEC_MAX;
      hit = 1'b1;
    end else if (q < VEC_MIN) begin
      q = VEC_MIN;
      hit = 1'b1;
    end
    return q[VEC_W-1:0];
  endfunction

  // Expected beat for one input beat at the current tolerance
  function automatic rot_result_t predict_rotation(input rot_item_t it);
    longint w, x, y, z, vx, vy, vz;
    longint ww, xx, yy, zz, dev;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    bit hx, hy, hz;
    rot_result_t res;
    w = it.q_w;
    x = it.q_x;
    y = it.q_y;
    z = it.q_z;
    vx = it.v_x;
    vy = it.v_y;
    vz = it.v_z;
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    res = '0;
    dev = ww + xx + yy + zz - UNIT_SQ;
    if (dev < 0) dev = -dev;
    if (dev > longint'(tolerance_now)) begin
      res.not_unit = 1'b1;
      return res;
    end
    m00 = ww + xx - yy - zz;
    m01 = 2 * (x * y - w * z);
    m02 = 2 * (x * z + w * y);
    m10 = 2 * (x * y + w * z);
    m11 = ww - xx + yy - zz;
    m12 = 2 * (y * z - w * x);
    m20 = 2 * (x * z - w * y);
    m21 = 2 * (y * z + w * x);
    m22 = ww - xx - yy + zz;
    res.r_x = round_clip(m00 * vx + m01 * vy + m02 * vz, hx);
    res.r_y = round_clip(m10 * vx + m11 * vy + m12 * vz, hy);
    res.r_z = round_clip(m20 * vx + m21 * vy + m22 * vz, hz);
    res.saturated = hx | hy | hz;
    return res;
  endfunction

  function automatic rot_item_t make_item(input int w, input int x, input int y,
                                          input int z, input int vx, input int vy,
                                          input int vz);
    rot_item_t it;
    it.q_w = Q_WIDTH'(w);
    it.q_x = Q_WIDTH'(x);
    it.q_y = Q_WIDTH'(y);
    it.q_z = Q_WIDTH'(z);
    it.v_x = VEC_W'(vx);
    it.v_y = VEC_W'(vy);
    it.v_z = VEC_W'(vz);
    return it;
  endfunction

  function automatic int to_q14(input real v);
    int r;
    r = $rtoi(v >= 0.0 ? v + 0.5 : v - 0.5);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Random direction, squared norm stretched by up to +/- spread around one
  function automatic rot_item_t near_unit_quat(input real spread);
    rot_item_t it;
    real a [4];
    real mag2, stretch, scale;
    it = '0;
    do begin
      mag2 = 0.0;
      for (int i = 0; i < 4; i++) begin
        a[i] = (real'($urandom_range(0, 65535)) - 32767.5) / 32767.5;
        mag2 += a[i] * a[i];
      end
    end while (mag2 < 0.01);
    stretch = 1.0 + spread * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
    if (stretch < 0.0) stretch = 0.0;
    scale = real'(Q_ONE) * $sqrt(stretch / mag2);
    it.q_w = Q_WIDTH'(to_q14(a[0] * scale));
    it.q_x = Q_WIDTH'(to_q14(a[1] * scale));
    it.q_y = Q_WIDTH'(to_q14(a[2] * scale));
    it.q_z = Q_WIDTH'(to_q14(a[3] * scale));
    return it;
  endfunction

  // Quaternions with a squared norm of exactly one
  function automatic rot_item_t exact_unit_quat();
    rot_item_t it;
    int comp [4];
    it = '0;
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 4; i++) comp[i] = $urandom_range(0, 1) ? Q_ONE / 2 : -Q_ONE / 2;
    end else begin
      for (int i = 0; i < 4; i++) comp[i] = 0;
      comp[$urandom_range(0, 3)] = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
    end
    it.q_w = Q_WIDTH'(comp[0]);
    it.q_x = Q_WIDTH'(comp[1]);
    it.q_y = Q_WIDTH'(comp[2]);
    it.q_z = Q_WIDTH'(comp[3]);
    return it;
  endfunction

  function automatic int extreme_q();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [VEC_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return VEC_W'($urandom());
      5, 6, 7: return VEC_W'(int'($urandom_range(0, 2000)) - 1000);
      8: return VEC_W'($urandom_range(0, 1) ? VEC_MAX : VEC_MIN);
      default: return VEC_W'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic rot_item_t random_rotation_item();
    rot_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it = near_unit_quat(real'(tolerance_now) * 1.5 / real'(TOL_ONE));
    end else if (pick < 75) begin
      it = exact_unit_quat();
    end else if (pick < 90) begin
      it.q_w = Q_WIDTH'($urandom());
      it.q_x = Q_WIDTH'($urandom());
      it.q_y = Q_WIDTH'($urandom());
      it.q_z = Q_WIDTH'($urandom());
    end else begin
      it.q_w = Q_WIDTH'(extreme_q());
      it.q_x = Q_WIDTH'(extreme_q());
      it.q_y = Q_WIDTH'(extreme_q());
      it.q_z = Q_WIDTH'(extreme_q());
    end
    it.v_x = random_coord();
    it.v_y = random_coord();
    it.v_z = random_coord();
    return it;
  endfunction

  // One input beat, with random idle cycles ahead of it
  task automatic send_rotation(input rot_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_rotations.push_back(predict_rotation(it));
  endtask

  // Hold off input until every expected beat is out and the pipe is empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (NUM_STAGES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance_now = value;
  endtask

  // Field extremes, half turns, clipping and rejects at the reset tolerance
  task automatic test_directed_rotations();
    send_rotation(make_item(Q_ONE, 0, 0, 0, 8388607, -8388608, 1));
    send_rotation(make_item(Q_ONE, 0, 0, 0, 0, -1, 12345));
    send_rotation(make_item(-Q_ONE, 0, 0, 0, -8388608, 8388607, -1));
    send_rotation(make_item(0, Q_ONE, 0, 0, 100, -8388608, 8388607));
    send_rotation(make_item(0, 0, Q_ONE, 0, -8388608, 5, -8388608));
    send_rotation(make_item(0, 0, 0, -Q_ONE, 7, -8388608, 3));
    send_rotation(make_item(11585, 0, 0, 11585, 8388607, 8388607, 0));
    send_rotation(make_item(8192, 8192, 8192, 8192, 1, 2, 3));
    send_rotation(make_item(8192, -8192, 8192, -8192, -8388608, 8388607, -8388608));
    send_rotation(make_item(-32768, -32768, -32768, -32768, 1, 1, 1));
    send_rotation(make_item(32767, 32767, 32767, 32767, -1, -1, -1));
    send_rotation(make_item(0, 0, 0, 0, 1000, 2000, 3000));
    send_rotation(make_item(16383, 0, 0, 0, 4194303, -4194304, 99));
  endtask

  // Accept/reject exactly at the tolerance edge, including zero tolerance
  task automatic test_norm_boundary();
    write_tolerance(32769);
    send_rotation(make_item(Q_ONE + 1, 0, 0, 0, 1000, -1000, 5));
    send_rotation(make_item(Q_ONE - 1, 0, 0, 0, 1000, -1000, 5));
    write_tolerance(32768);
    send_rotation(make_item(Q_ONE + 1, 0, 0, 0, 1000, -1000, 5));
    send_rotation(make_item(Q_ONE - 1, 0, 0, 0, 1000, -1000, 5));
    write_tolerance(32766);
    send_rotation(make_item(Q_ONE - 1, 0, 0, 0, 1000, -1000, 5));
    send_rotation(make_item(0, 0, Q_ONE, 0, 1000, -1000, 5));
    write_tolerance(0);
    send_rotation(make_item(Q_ONE, 0, 0, 0, 8388607, 0, -8388608));
    send_rotation(make_item(Q_ONE + 1, 0, 0, 0, 8388607, 0, -8388608));
    send_rotation(make_item(8192, 8192, -8192, 8192, 123456, -654321, 42));
  endtask

  // Tolerance of one: zero quaternion passes, rounding ties, scaled-up clipping
  task automatic test_loose_tolerance();
    write_tolerance(TOL_WIDTH'(TOL_ONE));
    send_rotation(make_item(0, 0, 0, 0, 8388607, -8388608, 77));
    send_rotation(make_item(8192, 0, 0, 0, 2, -2, 6));
    send_rotation(make_item(8192, 0, 0, 0, -6, 3, -3));
    send_rotation(make_item(23170, 0, 0, 0, 8388607, -8388608, 4194304));
    send_rotation(make_item(0, 0, 0, -23170, 4194304, -4194305, 1));
    send_rotation(make_item(Q_ONE, Q_ONE, 0, 0, 3000000, -3000000, 5000000));
    send_rotation(make_item(Q_ONE, Q_ONE, 0, 1, 3000000, -3000000, 5000000));
    send_rotation(make_item(32767, 0, 0, 0, 1, 1, 1));
  endtask

  // Random beats under one idle/stall mix, with a full drain midway
  task automatic test_random_phase(input int idle_pct, input int stall,
                                   input int unsigned tol);
    write_tolerance(TOL_WIDTH'(tol));
    in_idle_pct = idle_pct;
    stall_pct = stall;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) drain_results();
      send_rotation(random_rotation_item());
    end
  endtask

  // Result side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin : rotation_check
    rot_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.r_x = out_tdata[VEC_W-1:0];
      got.r_y = out_tdata[2*VEC_W-1:VEC_W];
      got.r_z = out_tdata[3*VEC_W-1:2*VEC_W];
      got.not_unit = out_tuser[TUSER_NOT_UNIT];
      got.saturated = out_tuser[TUSER_SATURATED];
      if (pending_rotations.size() == 0) begin
        $error("result beat with no rotation pending");
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        if (got.r_x !== want.r_x) begin
          $error("r_x: expected %0d, got %0d", want.r_x, got.r_x);
          mismatch_count++;
        end
        if (got.r_y !== want.r_y) begin
          $error("r_y: expected %0d, got %0d", want.r_y, got.r_y);
          mismatch_count++;
        end
        if (got.r_z !== want.r_z) begin
          $error("r_z: expected %0d, got %0d", want.r_z, got.r_z);
          mismatch_count++;
        end
        if (got.not_unit !== want.not_unit) begin
          $error("not_unit: expected %0b, got %0b", want.not_unit, got.not_unit);
          mismatch_count++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quaternion_vector_rotate_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_rotations();
    test_norm_boundary();
    test_loose_tolerance();
    test_random_phase(0, 0, TOL_RESET);
    test_random_phase(47, 0, TOL_ONE);
    test_random_phase(0, 47, 0);
    test_random_phase(20, 20, $urandom_range(1, TOL_ONE - 1));
    test_random_phase(0, 0, 1000000);
    drain_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quaternion_vector_rotate_unit regression: pass");
    end else begin
      $display("quaternion_vector_rotate_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_unit.sv
tb/sv/quaternion_vector_rotate_unit_tb.sv
